// ===== src/wkge_pkg.sv =====
// ----------------------------------------------------------------------------
// wkge_pkg
// Shared types, constants and the evaluation microprogram of the weighted
// KGE block.
// ----------------------------------------------------------------------------
`default_nettype none

package wkge_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int MAX_PAIRS   = 65536;
    localparam int COUNT_BITS  = 17;
    localparam int SUM_BITS    = 41;
    localparam int SQ_BITS     = 63;
    localparam int XP_BITS     = 64;
    localparam int W_BITS      = 16;
    localparam int S_BITS      = 18;
    localparam int WIDE        = 128;
    localparam int HALF        = 64;
    localparam int D_BITS      = 41;
    localparam int EFF_BITS    = 32;
    localparam int PC_BITS     = 5;
    localparam int CNT_BITS    = 8;

    localparam logic [COUNT_BITS-1:0] MAX_COUNT  = COUNT_BITS'(MAX_PAIRS);
    localparam logic [W_BITS-1:0]     WEIGHT_ONE = 16'd256;
    localparam logic [7:0]            FRAC_R     = 8'd78;
    localparam logic [7:0]            FRAC_D     = 8'd16;
    localparam logic [7:0]            FRAC_NONE  = 8'd0;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_NO_DATA    = 2'd1,
        STAT_DEGENERATE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CFG_WEIGHT_CORR = 2'd0,
        CFG_WEIGHT_VAR  = 2'd1,
        CFG_WEIGHT_BIAS = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        OP_MUL, OP_DIV, OP_SQRT, OP_ADD, OP_SUB, OP_COMB, OP_CHKV, OP_END
    } op_t;

    typedef enum logic [4:0] {
        SRC_ZERO, SRC_N, SRC_SXX, SRC_SYY, SRC_CM, SRC_XM, SRC_YM, SRC_DYX,
        SRC_WR, SRC_WV, SRC_WB, SRC_S, SRC_SSH, SRC_A, SRC_B, SRC_ABD, SRC_M,
        SRC_DR, SRC_DA, SRC_DB, SRC_T0, SRC_T1, SRC_T2, SRC_C, SRC_VXS, SRC_VYS
    } src_t;

    typedef enum logic [3:0] {
        DST_NONE, DST_T0, DST_T1, DST_T2, DST_VX, DST_VY, DST_C, DST_A, DST_B,
        DST_RQ, DST_DR, DST_DA, DST_DB, DST_R
    } dst_t;

    typedef enum logic [2:0] {
        CS_ACC, CS_CHECK, CS_FETCH, CS_WAIT, CS_DONE
    } ctrl_state_t;

    typedef struct packed {
        op_t        op;
        src_t       sa;
        src_t       sb;
        dst_t       dst;
        logic [7:0] frac;
    } uop_t;

    typedef struct packed {
        logic    acc_en;
        logic    start;
        logic    wr;
        logic    load_out;
        uop_t    uop;
        status_t res_status;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
        logic no_data;
        logic degen_pre;
        logic var_zero;
        logic out_busy;
    } dp_stat_t;

    // Evaluation sequence: variances, covariance, roots, ratios, final root.
    function automatic uop_t ucode(input logic [PC_BITS-1:0] pc);
        uop_t u;
        case (pc)
            5'd0:    u = '{OP_MUL,  SRC_N,   SRC_SXX,  DST_T0, FRAC_NONE};
            5'd1:    u = '{OP_MUL,  SRC_XM,  SRC_XM,   DST_T1, FRAC_NONE};
            5'd2:    u = '{OP_SUB,  SRC_T0,  SRC_T1,   DST_VX, FRAC_NONE};
            5'd3:    u = '{OP_MUL,  SRC_N,   SRC_SYY,  DST_T0, FRAC_NONE};
            5'd4:    u = '{OP_MUL,  SRC_YM,  SRC_YM,   DST_T1, FRAC_NONE};
            5'd5:    u = '{OP_SUB,  SRC_T0,  SRC_T1,   DST_VY, FRAC_NONE};
            5'd6:    u = '{OP_CHKV, SRC_ZERO, SRC_ZERO, DST_NONE, FRAC_NONE};
            5'd7:    u = '{OP_MUL,  SRC_N,   SRC_CM,   DST_T0, FRAC_NONE};
            5'd8:    u = '{OP_MUL,  SRC_XM,  SRC_YM,   DST_T1, FRAC_NONE};
            5'd9:    u = '{OP_COMB, SRC_T0,  SRC_T1,   DST_C,  FRAC_NONE};
            5'd10:   u = '{OP_SQRT, SRC_VXS, SRC_ZERO, DST_A,  FRAC_NONE};
            5'd11:   u = '{OP_SQRT, SRC_VYS, SRC_ZERO, DST_B,  FRAC_NONE};
            5'd12:   u = '{OP_MUL,  SRC_A,   SRC_B,    DST_T0, FRAC_NONE};
            5'd13:   u = '{OP_DIV,  SRC_C,   SRC_T0,   DST_RQ, FRAC_R};
            5'd14:   u = '{OP_MUL,  SRC_WR,  SRC_M,    DST_T0, FRAC_NONE};
            5'd15:   u = '{OP_DIV,  SRC_T0,  SRC_SSH,  DST_DR, FRAC_NONE};
            5'd16:   u = '{OP_MUL,  SRC_WV,  SRC_ABD,  DST_T0, FRAC_NONE};
            5'd17:   u = '{OP_MUL,  SRC_S,   SRC_A,    DST_T1, FRAC_NONE};
            5'd18:   u = '{OP_DIV,  SRC_T0,  SRC_T1,   DST_DA, FRAC_D};
            5'd19:   u = '{OP_MUL,  SRC_WB,  SRC_DYX,  DST_T0, FRAC_NONE};
            5'd20:   u = '{OP_MUL,  SRC_S,   SRC_XM,   DST_T1, FRAC_NONE};
            5'd21:   u = '{OP_DIV,  SRC_T0,  SRC_T1,   DST_DB, FRAC_D};
            5'd22:   u = '{OP_MUL,  SRC_DR,  SRC_DR,   DST_T0, FRAC_NONE};
            5'd23:   u = '{OP_MUL,  SRC_DA,  SRC_DA,   DST_T1, FRAC_NONE};
            5'd24:   u = '{OP_ADD,  SRC_T0,  SRC_T1,   DST_T2, FRAC_NONE};
            5'd25:   u = '{OP_MUL,  SRC_DB,  SRC_DB,   DST_T0, FRAC_NONE};
            5'd26:   u = '{OP_ADD,  SRC_T2,  SRC_T0,   DST_T2, FRAC_NONE};
            5'd27:   u = '{OP_SQRT, SRC_T2,  SRC_ZERO, DST_R,  FRAC_NONE};
            default: u = '{OP_END,  SRC_ZERO, SRC_ZERO, DST_NONE, FRAC_NONE};
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// ===== src/wkge_if.sv =====
// ----------------------------------------------------------------------------
// wkge_sample_if / wkge_result_if
// Valid/ready channels for sample pairs and evaluation results.
// ----------------------------------------------------------------------------
`default_nettype none

interface wkge_sample_if import wkge_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sim_value;
    logic signed [SAMPLE_BITS-1:0] obs_value;
    logic                          obs_present;
    logic                          last_item;

    modport source (output valid, sim_value, obs_value, obs_present, last_item,
                    input ready);
    modport sink   (input valid, sim_value, obs_value, obs_present, last_item,
                    output ready);
endinterface

interface wkge_result_if import wkge_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [EFF_BITS-1:0]   efficiency;
    logic [1:0]            status;
    logic [COUNT_BITS-1:0] pairs_used;

    modport source (output valid, efficiency, status, pairs_used, input ready);
    modport sink   (input valid, efficiency, status, pairs_used, output ready);
endinterface

`default_nettype wire

// ===== src/wkge_arith.sv =====
// ----------------------------------------------------------------------------
// wkge_arith
// Shared iterative unit: 128x64 shift-add multiply, restoring fractional
// divide with saturation, and digit-by-digit square root of a 128-bit word.
// ----------------------------------------------------------------------------
`default_nettype none

module wkge_arith import wkge_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  op_t             op,
    input  logic [WIDE-1:0] a,
    input  logic [WIDE-1:0] b,
    input  logic [7:0]      frac,
    output logic            done,
    output logic [WIDE-1:0] result
);

    logic                busy_reg;
    logic                done_reg;
    op_t                 op_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [CNT_BITS-1:0] last_reg;

    logic [WIDE-1:0]     x_reg, x_next;
    logic [WIDE-1:0]     d_reg;
    logic [HALF-1:0]     y_reg, y_next;
    logic [WIDE:0]       acc_reg, acc_next;
    logic                sat_reg, sat_next;

    logic [WIDE:0]       rem_sh;
    logic [67:0]         rem4;
    logic [67:0]         trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == last_reg)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        x_next   = x_reg;
        y_next   = y_reg;
        acc_next = acc_reg;
        sat_next = sat_reg;
        rem_sh   = {acc_reg[WIDE-1:0], x_reg[WIDE-1]};
        rem4     = {acc_reg[65:0], x_reg[WIDE-1 -: 2]};
        trial    = {2'b00, y_reg, 2'b01};
        case (op_reg)
            OP_MUL:
            begin
                if (y_reg[0])
                    acc_next = {1'b0, acc_reg[WIDE-1:0] + x_reg};
                x_next = x_reg << 1;
                y_next = y_reg >> 1;
            end
            OP_DIV:
            begin
                // Numerator bits run out into zeros once shifted past.
                x_next = x_reg << 1;
                if (y_reg[HALF-1])
                    sat_next = 1'b1;
                if (rem_sh >= {1'b0, d_reg})
                begin
                    acc_next = rem_sh - {1'b0, d_reg};
                    y_next   = {y_reg[HALF-2:0], 1'b1};
                end
                else
                begin
                    acc_next = rem_sh;
                    y_next   = {y_reg[HALF-2:0], 1'b0};
                end
            end
            OP_SQRT:
            begin
                x_next = x_reg << 2;
                if (rem4 >= trial)
                begin
                    acc_next = (WIDE+1)'(rem4 - trial);
                    y_next   = {y_reg[HALF-2:0], 1'b1};
                end
                else
                begin
                    acc_next = (WIDE+1)'(rem4);
                    y_next   = {y_reg[HALF-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg   <= op;
            x_reg    <= a;
            d_reg    <= b;
            y_reg    <= (op == OP_MUL) ? b[HALF-1:0] : '0;
            acc_reg  <= '0;
            sat_reg  <= 1'b0;
            last_reg <= (op == OP_DIV) ? 8'd127 + frac : 8'd63;
        end
        else if (busy_reg)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            acc_reg <= acc_next;
            sat_reg <= sat_next;
        end
    end

    always_comb
    begin
        case (op_reg)
            OP_MUL:  result = acc_reg[WIDE-1:0];
            OP_DIV:  result = sat_reg ? {{HALF{1'b0}}, {HALF{1'b1}}}
                                      : {{HALF{1'b0}}, y_reg};
            default: result = {{HALF{1'b0}}, y_reg};
        endcase
    end

    assign done = done_reg;

endmodule

`default_nettype wire

// ===== src/wkge_ctrl.sv =====
// ----------------------------------------------------------------------------
// wkge_ctrl
// Sequencer: accepts pairs, then steps the evaluation microprogram and
// hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wkge_ctrl import wkge_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     last_item,
    output logic     in_ready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    ctrl_state_t        state_reg, state_next;
    logic [PC_BITS-1:0] pc_reg, pc_next;
    status_t            status_reg, status_next;
    uop_t               uop;

    assign uop = ucode(pc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= CS_ACC;
            pc_reg     <= '0;
            status_reg <= STAT_OK;
        end
        else
        begin
            state_reg  <= state_next;
            pc_reg     <= pc_next;
            status_reg <= status_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        status_next    = status_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.uop        = uop;
        cmd.res_status = status_reg;
        case (state_reg)
            CS_ACC:
            begin
                in_ready   = 1'b1;
                cmd.acc_en = in_valid;
                if (in_valid && last_item)
                    state_next = CS_CHECK;
            end
            CS_CHECK:
            begin
                pc_next = '0;
                if (stat.no_data)
                begin
                    status_next = STAT_NO_DATA;
                    state_next  = CS_DONE;
                end
                else if (stat.degen_pre)
                begin
                    status_next = STAT_DEGENERATE;
                    state_next  = CS_DONE;
                end
                else
                    state_next = CS_FETCH;
            end
            CS_FETCH:
            begin
                case (uop.op)
                    OP_MUL, OP_DIV, OP_SQRT:
                    begin
                        cmd.start  = 1'b1;
                        state_next = CS_WAIT;
                    end
                    OP_ADD, OP_SUB, OP_COMB:
                    begin
                        cmd.wr  = 1'b1;
                        pc_next = pc_reg + 1'b1;
                    end
                    OP_CHKV:
                    begin
                        if (stat.var_zero)
                        begin
                            status_next = STAT_DEGENERATE;
                            state_next  = CS_DONE;
                        end
                        else
                            pc_next = pc_reg + 1'b1;
                    end
                    default:
                    begin
                        status_next = STAT_OK;
                        state_next  = CS_DONE;
                    end
                endcase
            end
            CS_WAIT:
            begin
                if (stat.done)
                begin
                    cmd.wr     = 1'b1;
                    pc_next    = pc_reg + 1'b1;
                    state_next = CS_FETCH;
                end
            end
            CS_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = CS_ACC;
                end
            end
            default: state_next = CS_ACC;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/wkge_dp.sv =====
// ----------------------------------------------------------------------------
// wkge_dp
// Datapath: weight registers, running sums, working registers of the
// evaluation, the shared arithmetic unit and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wkge_dp import wkge_pkg::*; (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [1:0]                    cfg_index,
    input  logic [W_BITS-1:0]             cfg_data,
    input  logic signed [SAMPLE_BITS-1:0] sim_value,
    input  logic signed [SAMPLE_BITS-1:0] obs_value,
    input  logic                          obs_present,
    input  dp_cmd_t                       cmd,
    output dp_stat_t                      stat,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [EFF_BITS-1:0]           efficiency,
    output logic [1:0]                    status,
    output logic [COUNT_BITS-1:0]         pairs_used
);

    localparam logic [HALF-1:0] RQ_ONE = 64'h4000_0000;
    localparam logic [HALF-1:0] R_SAT  = 64'h8001_0000;
    localparam logic [WIDE-1:0] D_CAP  = WIDE'(1) << 40;

    logic [W_BITS-1:0]            wr_reg, wv_reg, wb_reg;
    logic [COUNT_BITS-1:0]        n_reg;
    logic signed [SUM_BITS-1:0]   xs_reg, ys_reg;
    logic [SQ_BITS-1:0]           xx_reg, yy_reg;
    logic signed [XP_BITS-1:0]    xy_reg;

    logic [WIDE-1:0]              t0_reg, t1_reg, t2_reg, vx_reg, vy_reg, c_reg;
    logic                         cneg_reg;
    logic [HALF-1:0]              a_reg, b_reg, rq_reg, r_reg;
    logic [D_BITS-1:0]            dr_reg, da_reg, db_reg;

    logic                         out_valid_reg;
    logic [EFF_BITS-1:0]          eff_reg;
    status_t                      stat_reg;
    logic [COUNT_BITS-1:0]        pairs_reg;

    logic signed [2*SAMPLE_BITS-1:0] xx_p, yy_p, xy_p;
    logic                         take;

    logic [SUM_BITS-1:0]          xm, ym;
    logic signed [SUM_BITS:0]     dyx_s;
    logic [SUM_BITS:0]            dyx_m;
    logic [XP_BITS-1:0]           cm;
    logic [S_BITS-1:0]            s_sum;
    logic [31:0]                  ssh;
    logic [HALF-1:0]              abd;
    logic [30:0]                  rqc;
    logic [31:0]                  m_val;

    logic [WIDE-1:0]              opa, opb, res, comb_c;
    logic                         comb_neg, pn, qn;
    logic                         arith_done;
    logic [WIDE-1:0]              arith_res;
    logic [D_BITS-1:0]            res_cap;
    logic signed [33:0]           eff_wide;
    logic [EFF_BITS-1:0]          eff_val;

    // ---------------- configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= WEIGHT_ONE;
            wv_reg <= WEIGHT_ONE;
            wb_reg <= WEIGHT_ONE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_WEIGHT_CORR: wr_reg <= cfg_data;
                CFG_WEIGHT_VAR:  wv_reg <= cfg_data;
                CFG_WEIGHT_BIAS: wb_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- accumulation, one transaction per cycle while the sequencer accepts pairs
    assign xx_p = obs_value * obs_value;
    assign yy_p = sim_value * sim_value;
    assign xy_p = obs_value * sim_value;
    assign take = cmd.acc_en && obs_present && (n_reg < MAX_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg  <= '0;
            xs_reg <= '0;
            ys_reg <= '0;
            xx_reg <= '0;
            yy_reg <= '0;
            xy_reg <= '0;
        end
        else if (cmd.load_out)
        begin
            n_reg  <= '0;
            xs_reg <= '0;
            ys_reg <= '0;
            xx_reg <= '0;
            yy_reg <= '0;
            xy_reg <= '0;
        end
        else if (take)
        begin
            n_reg  <= n_reg + 1'b1;
            xs_reg <= xs_reg + SUM_BITS'(obs_value);
            ys_reg <= ys_reg + SUM_BITS'(sim_value);
            xx_reg <= xx_reg + SQ_BITS'($unsigned(xx_p));
            yy_reg <= yy_reg + SQ_BITS'($unsigned(yy_p));
            xy_reg <= xy_reg + XP_BITS'(xy_p);
        end
    end

    // ---------------- derived operands
    assign xm    = xs_reg[SUM_BITS-1] ? SUM_BITS'(-xs_reg) : SUM_BITS'(xs_reg);
    assign ym    = ys_reg[SUM_BITS-1] ? SUM_BITS'(-ys_reg) : SUM_BITS'(ys_reg);
    assign dyx_s = (SUM_BITS+1)'(ys_reg) - (SUM_BITS+1)'(xs_reg);
    assign dyx_m = dyx_s[SUM_BITS] ? (SUM_BITS+1)'(-dyx_s) : (SUM_BITS+1)'(dyx_s);
    assign cm    = xy_reg[XP_BITS-1] ? XP_BITS'(-xy_reg) : XP_BITS'(xy_reg);
    assign s_sum = S_BITS'(wr_reg) + S_BITS'(wv_reg) + S_BITS'(wb_reg);
    assign ssh   = {s_sum, 14'b0};
    assign abd   = (b_reg > a_reg) ? b_reg - a_reg : a_reg - b_reg;
    assign rqc   = (rq_reg > RQ_ONE) ? RQ_ONE[30:0] : rq_reg[30:0];
    assign m_val = cneg_reg ? 32'(RQ_ONE) + 32'(rqc) : 32'(RQ_ONE) - 32'(rqc);

    always_comb
    begin
        case (cmd.uop.sa)
            SRC_N:   opa = WIDE'(n_reg);
            SRC_SXX: opa = WIDE'(xx_reg);
            SRC_SYY: opa = WIDE'(yy_reg);
            SRC_CM:  opa = WIDE'(cm);
            SRC_XM:  opa = WIDE'(xm);
            SRC_YM:  opa = WIDE'(ym);
            SRC_DYX: opa = WIDE'(dyx_m);
            SRC_WR:  opa = WIDE'(wr_reg);
            SRC_WV:  opa = WIDE'(wv_reg);
            SRC_WB:  opa = WIDE'(wb_reg);
            SRC_S:   opa = WIDE'(s_sum);
            SRC_SSH: opa = WIDE'(ssh);
            SRC_A:   opa = WIDE'(a_reg);
            SRC_B:   opa = WIDE'(b_reg);
            SRC_ABD: opa = WIDE'(abd);
            SRC_M:   opa = WIDE'(m_val);
            SRC_DR:  opa = WIDE'(dr_reg);
            SRC_DA:  opa = WIDE'(da_reg);
            SRC_DB:  opa = WIDE'(db_reg);
            SRC_T0:  opa = t0_reg;
            SRC_T1:  opa = t1_reg;
            SRC_T2:  opa = t2_reg;
            SRC_C:   opa = c_reg;
            SRC_VXS: opa = vx_reg << 48;
            SRC_VYS: opa = vy_reg << 48;
            default: opa = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.uop.sb)
            SRC_N:   opb = WIDE'(n_reg);
            SRC_SXX: opb = WIDE'(xx_reg);
            SRC_SYY: opb = WIDE'(yy_reg);
            SRC_CM:  opb = WIDE'(cm);
            SRC_XM:  opb = WIDE'(xm);
            SRC_YM:  opb = WIDE'(ym);
            SRC_DYX: opb = WIDE'(dyx_m);
            SRC_WR:  opb = WIDE'(wr_reg);
            SRC_WV:  opb = WIDE'(wv_reg);
            SRC_WB:  opb = WIDE'(wb_reg);
            SRC_S:   opb = WIDE'(s_sum);
            SRC_SSH: opb = WIDE'(ssh);
            SRC_A:   opb = WIDE'(a_reg);
            SRC_B:   opb = WIDE'(b_reg);
            SRC_ABD: opb = WIDE'(abd);
            SRC_M:   opb = WIDE'(m_val);
            SRC_DR:  opb = WIDE'(dr_reg);
            SRC_DA:  opb = WIDE'(da_reg);
            SRC_DB:  opb = WIDE'(db_reg);
            SRC_T0:  opb = t0_reg;
            SRC_T1:  opb = t1_reg;
            SRC_T2:  opb = t2_reg;
            SRC_C:   opb = c_reg;
            SRC_VXS: opb = vx_reg << 48;
            SRC_VYS: opb = vy_reg << 48;
            default: opb = '0;
        endcase
    end

    // ---------------- signed covariance from magnitudes p = n|Sxy|, q = |X||Y|
    assign pn = xy_reg[XP_BITS-1];
    assign qn = xs_reg[SUM_BITS-1] ^ ys_reg[SUM_BITS-1];

    always_comb
    begin
        if (pn != qn)
        begin
            comb_c   = opa + opb;
            comb_neg = pn;
        end
        else if (opa >= opb)
        begin
            comb_c   = opa - opb;
            comb_neg = pn;
        end
        else
        begin
            comb_c   = opb - opa;
            comb_neg = !pn;
        end
    end

    wkge_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.start),
        .op     (cmd.uop.op),
        .a      (opa),
        .b      (opb),
        .frac   (cmd.uop.frac),
        .done   (arith_done),
        .result (arith_res)
    );

    always_comb
    begin
        case (cmd.uop.op)
            OP_ADD:  res = opa + opb;
            OP_SUB:  res = opa - opb;
            OP_COMB: res = comb_c;
            default: res = arith_res;
        endcase
    end

    assign res_cap = (res > D_CAP) ? D_CAP[D_BITS-1:0] : res[D_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            case (cmd.uop.dst)
                DST_T0: t0_reg <= res;
                DST_T1: t1_reg <= res;
                DST_T2: t2_reg <= res;
                DST_VX: vx_reg <= res;
                DST_VY: vy_reg <= res;
                DST_C:
                begin
                    c_reg    <= res;
                    cneg_reg <= comb_neg;
                end
                DST_A:  a_reg  <= res[HALF-1:0];
                DST_B:  b_reg  <= res[HALF-1:0];
                DST_RQ: rq_reg <= res[HALF-1:0];
                DST_DR: dr_reg <= res_cap;
                DST_DA: da_reg <= res_cap;
                DST_DB: db_reg <= res_cap;
                DST_R:  r_reg  <= res[HALF-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- status to the sequencer
    assign stat.done      = arith_done;
    assign stat.no_data   = (n_reg == '0);
    assign stat.degen_pre = (n_reg < COUNT_BITS'(2)) || (xs_reg == '0) || (s_sum == '0);
    assign stat.var_zero  = (vx_reg == '0) || (vy_reg == '0);
    assign stat.out_busy  = out_valid_reg && !out_ready;

    // ---------------- output register, 1.0 - root, saturated below
    assign eff_wide = 34'sd65536 - $signed({1'b0, r_reg[32:0]});
    assign eff_val  = (r_reg > R_SAT) ? 32'h8000_0000 : eff_wide[EFF_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            eff_reg   <= (cmd.res_status == STAT_OK) ? eff_val : '0;
            stat_reg  <= cmd.res_status;
            pairs_reg <= n_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign efficiency = eff_reg;
    assign status     = stat_reg;
    assign pairs_used = pairs_reg;

endmodule

`default_nettype wire

// ===== src/weighted_kling_gupta_efficiency.sv =====
// Sample pairs: one transaction per cycle while accumulating; none are taken
// during evaluation. After the transaction marked last, the evaluation runs
// 15 multiplies, 3 roots and 4 divides in the shared iterative unit; too few
// pairs, zero observed mean or zero weight sum end it before any of these,
// and zero variance ends it after the variances. The result waits in an
// output register. Reset clears all sums and sets every weight to 1.0.
// ----------------------------------------------------------------------------
// weighted_kling_gupta_efficiency
// Top level: sequencer and datapath of the weighted KGE evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_kling_gupta_efficiency import wkge_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    wkge_sample_if.sink        samples,
    wkge_result_if.source      results,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [W_BITS-1:0]  cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    wkge_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .last_item (samples.last_item),
        .in_ready  (samples.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    wkge_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sim_value   (samples.sim_value),
        .obs_value   (samples.obs_value),
        .obs_present (samples.obs_present),
        .cmd         (cmd),
        .stat        (stat),
        .out_ready   (results.ready),
        .out_valid   (results.valid),
        .efficiency  (results.efficiency),
        .status      (results.status),
        .pairs_used  (results.pairs_used)
    );

endmodule

`default_nettype wire

// ===== test/wkge_tb_if.sv =====
// ----------------------------------------------------------------------------
// wkge_tb_if
// Result record used by the bench; the sample and result channels
// themselves come from src/wkge_if.sv.
// ----------------------------------------------------------------------------
package wkge_tb_pkg;
    import wkge_pkg::*;

    typedef struct {
        logic signed [31:0] eff;
        status_t            status;
        logic [16:0]        pairs;
    } kge_result_t;
endpackage

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the weighted KGE block. Series of sample pairs go
// through the block under several weight settings. A bit-exact software
// model of the evaluation predicts each series score, which is checked field
// by field. Directed series cover the corner cases, then random series follow.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import wkge_pkg::*;
    import wkge_tb_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [1:0] cfg_index = CFG_WEIGHT_CORR;
    logic [15:0] cfg_data = '0;

    wkge_sample_if samples();
    wkge_result_if results();

    weighted_kling_gupta_efficiency u_dut (
        .clk(clk), .rst_n(rst_n), .samples(samples), .results(results),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // weights and series accumulators
    logic [15:0] w_corr, w_var, w_bias;
    logic [16:0] n_acc;
    logic signed [63:0] sx, sy, sxy;
    logic [63:0] sxx, syy;

    kge_result_t score_q[$];
    int errors = 0;
    int idle_tx = 0, idle_rx = 0; // percentages
    int quiet = 0;
    int fed = 0;

    function automatic logic [63:0] isqrt128(input logic [127:0] x);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            c = r | (64'd1 << i);
            if ({64'd0, c} * {64'd0, c} <= x) r = c;
        end
        return r;
    endfunction

    // floor(n*2^f/d), saturated at all ones
    function automatic logic [63:0] divfix(input logic [127:0] n,
                                           input logic [127:0] d, input int f);
        logic [255:0] q;
        if (d == 0) return '1;
        q = ({128'd0, n} << f) / {128'd0, d};
        if (q[255:64] != 0) return '1;
        return q[63:0];
    endfunction

    function automatic logic [63:0] capd(input logic [63:0] d);
        return d > (64'd1 << 40) ? (64'd1 << 40) : d;
    endfunction

    function automatic logic [63:0] absv(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic kge_result_t score_series();
        kge_result_t r;
        logic [127:0] vx, vy, p, q, c, ssum;
        logic [63:0] s, a, b, rq, m, dr, da, db;
        logic cneg, pn, qn;
        longint e;
        r.eff = 0;
        r.pairs = n_acc;
        s = w_corr + w_var + w_bias;
        if (n_acc == 0) begin
            r.status = STAT_NO_DATA;
            return r;
        end
        r.status = STAT_DEGENERATE;
        if (n_acc < 2 || sx == 0 || s == 0) return r;
        vx = 128'(n_acc) * sxx - 128'(absv(sx)) * absv(sx);
        vy = 128'(n_acc) * syy - 128'(absv(sy)) * absv(sy);
        if (vx == 0 || vy == 0) return r;
        pn = sxy < 0;
        p = 128'(n_acc) * absv(sxy);
        qn = (sx < 0) != (sy < 0);
        q = 128'(absv(sx)) * absv(sy);
        if (pn != qn) begin c = p + q; cneg = pn; end
        else if (p >= q) begin c = p - q; cneg = pn; end
        else begin c = q - p; cneg = !pn; end
        a = isqrt128(vx << 48);
        b = isqrt128(vy << 48);
        rq = divfix(c, 128'(a) * b, 78);
        if (rq > (64'd1 << 30)) rq = 64'd1 << 30;
        m = cneg ? (64'd1 << 30) + rq : (64'd1 << 30) - rq;
        dr = capd((64'(w_corr) * m) / (s << 14));
        da = capd(divfix(128'(w_var) * (b > a ? b - a : a - b), 128'(s) * a, 16));
        db = capd(divfix(128'(w_bias) * absv(sy - sx), 128'(s) * absv(sx), 16));
        ssum = 128'(dr) * dr + 128'(da) * da + 128'(db) * db;
        e = 65536 - longint'(isqrt128(ssum));
        if (e < -64'sd2147483648) e = -64'sd2147483648;
        r.eff = 32'(e);
        r.status = STAT_OK;
        return r;
    endfunction

    function automatic void take_pair(input logic [23:0] sim, input logic [23:0] obs,
                                      input logic present, input logic last);
        longint x, y;
        x = longint'($signed(obs));
        y = longint'($signed(sim));
        if (present && n_acc < MAX_PAIRS) begin
            n_acc++;
            sx += x; sy += y;
            sxx += 64'(x * x); syy += 64'(y * y); sxy += x * y;
        end
        if (last) begin
            score_q.insert(score_q.size(), score_series());
            n_acc = '0; sx = '0; sy = '0; sxx = '0; syy = '0; sxy = '0;
        end
    endfunction

    // directed rows; exp_on marks rows whose score is typed in
    typedef struct {
        logic [23:0] sim, obs;
        logic present, last, exp_on;
        kge_result_t exp_res;
    } pair_row_t;

    // result side: check and drive ready
    always @(posedge clk) begin
        kge_result_t e;
        if (rst_n && results.valid && results.ready) begin
            if (score_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: exp none got eff=%0d",
                             $signed(results.efficiency));
            end else begin
                e = score_q.pop_front();
                if (e.eff !== results.efficiency || e.status !== results.status
                    || e.pairs !== results.pairs_used) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp eff=%0d st=%0d n=%0d got eff=%0d st=%0d n=%0d",
                                 e.eff, e.status, e.pairs, $signed(results.efficiency),
                                 results.status, results.pairs_used);
                end
            end
        end
    end

    always @(negedge clk)
        results.ready <= ($urandom_range(99) >= idle_rx);

    // watchdog: ends the run on a long quiet spell; receiver stalls stretch it little
    always @(posedge clk) begin
        if ((samples.valid && samples.ready) || (results.valid && results.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > 20000) begin
            $display("FAILURE");
            $finish;
        end
    end

    // valid stays up after the transaction; drain, or an idle spell in the next call, drops it
    task automatic send_pair(input logic [23:0] sim, input logic [23:0] obs,
                             input logic present, input logic last);
        while ($urandom_range(99) < idle_tx) begin
            samples.valid <= 1'b0;
            @(negedge clk);
        end
        samples.valid <= 1'b1;
        samples.sim_value <= sim;
        samples.obs_value <= obs;
        samples.obs_present <= present;
        samples.last_item <= last;
        do @(posedge clk); while (!samples.ready);
        take_pair(sim, obs, present, last);
        fed++;
        @(negedge clk);
    endtask

    task automatic drain();
        samples.valid <= 1'b0;
        while (score_q.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_weight(input cfg_index_t idx, input logic [15:0] v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(negedge clk);
        case (idx)
            CFG_WEIGHT_CORR: w_corr = v;
            CFG_WEIGHT_VAR:  w_var = v;
            default:         w_bias = v;
        endcase
    endtask

    task automatic set_weights(input logic [15:0] r, input logic [15:0] v,
                               input logic [15:0] b);
        drain();
        set_weight(CFG_WEIGHT_CORR, r);
        set_weight(CFG_WEIGHT_VAR, v);
        set_weight(CFG_WEIGHT_BIAS, b);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [23:0] rnd_sample(input int mode);
        case (mode)
            0: return 24'($urandom);
            1: return 24'($urandom_range(200)) - 24'd100;
            2: return $urandom_range(1) ? 24'h7fffff - 24'($urandom_range(3))
                                        : 24'h800000 + 24'($urandom_range(3));
            default: return 24'($urandom_range(4000)) + 24'd1000;
        endcase
    endfunction

    task automatic random_series(input int len);
        int mode;
        logic [23:0] o, s;
        mode = $urandom_range(3);
        for (int i = 0; i < len; i++) begin
            o = rnd_sample(mode);
            s = $urandom_range(3) == 0 ? rnd_sample($urandom_range(3))
                                       : o + 24'($urandom_range(400)) - 24'd200;
            send_pair(s, o, $urandom_range(9) != 0, i == len - 1);
        end
    endtask

    pair_row_t rows[18];

    function automatic pair_row_t row(input logic [23:0] s, input logic [23:0] o,
                                      input logic p, input logic l, input logic eo,
                                      input status_t st, input logic [16:0] n);
        pair_row_t r;
        r.sim = s; r.obs = o; r.present = p; r.last = l; r.exp_on = eo;
        r.exp_res.eff = 0; r.exp_res.status = st; r.exp_res.pairs = n;
        return r;
    endfunction

    initial begin
        kge_result_t pred;
        samples.valid = 1'b0;
        samples.sim_value = '0;
        samples.obs_value = '0;
        samples.obs_present = 1'b0;
        samples.last_item = 1'b0;
        w_corr = WEIGHT_ONE; w_var = WEIGHT_ONE; w_bias = WEIGHT_ONE;
        n_acc = '0; sx = '0; sy = '0; sxx = '0; syy = '0; sxy = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // directed table
        rows[0]  = row(24'd0, 24'd0, 1'b0, 1'b1, 1'b1, STAT_NO_DATA, 17'd0);
        rows[1]  = row(24'd5, 24'd7, 1'b1, 1'b1, 1'b1, STAT_DEGENERATE, 17'd1);
        rows[2]  = row(24'd3, 24'd4, 1'b1, 1'b0, 1'b0, STAT_OK, 17'd0);
        rows[3]  = row(24'd3, 24'd4, 1'b1, 1'b1, 1'b1, STAT_DEGENERATE, 17'd2);
        rows[4]  = row(24'd1, 24'd5, 1'b1, 1'b0, 1'b0, STAT_OK, 17'd0);
        rows[5]  = row(24'd2, -24'sd5, 1'b1, 1'b1, 1'b1, STAT_DEGENERATE, 17'd2);
        rows[6]  = row(24'h7fffff, 24'h800000, 1'b1, 1'b0, 1'b0, STAT_OK, 17'd0);
        rows[7]  = row(24'h800000, 24'h7fffff, 1'b1, 1'b0, 1'b0, STAT_OK, 17'd0);
        rows[8]  = row(24'h123456, 24'hffffff, 1'b0, 1'b0, 1'b0, STAT_OK, 17'd0);
        rows[9]  = row(24'h7fffff, 24'h7fffff, 1'b1, 1'b1, 1'b0, STAT_OK, 17'd0);
        rows[10] = row(24'd10, 24'd10, 1'b1, 1'b0, 1'b0, STAT_OK, 17'd0);
        rows[11] = row(24'd20, 24'd20, 1'b1, 1'b0, 1'b0, STAT_OK, 17'd0);
        rows[12] = row(24'd30, 24'd31, 1'b1, 1'b1, 1'b0, STAT_OK, 17'd0);
        rows[13] = row(-24'sd10, 24'd10, 1'b1, 1'b0, 1'b0, STAT_OK, 17'd0);
        rows[14] = row(-24'sd20, 24'd20, 1'b1, 1'b0, 1'b0, STAT_OK, 17'd0);
        rows[15] = row(-24'sd30, 24'd31, 1'b1, 1'b1, 1'b0, STAT_OK, 17'd0);
        rows[16] = row(24'd9, 24'd1, 1'b1, 1'b0, 1'b0, STAT_OK, 17'd0);
        rows[17] = row(-24'sd9, 24'd2, 1'b1, 1'b1, 1'b0, STAT_OK, 17'd0);
        foreach (rows[i]) begin
            send_pair(rows[i].sim, rows[i].obs, rows[i].present, rows[i].last);
            if (rows[i].exp_on) begin
                pred = score_q[$];
                if (pred.status !== rows[i].exp_res.status
                    || pred.pairs !== rows[i].exp_res.pairs || pred.eff !== 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("directed row %0d: exp st=%0d n=%0d eff=0 got st=%0d n=%0d eff=%0d",
                                 i, rows[i].exp_res.status, rows[i].exp_res.pairs,
                                 pred.status, pred.pairs, pred.eff);
                end
            end
        end

        // zero weight sum is degenerate
        set_weights(16'd0, 16'd0, 16'd0);
        send_pair(24'd1, 24'd2, 1'b1, 1'b0);
        send_pair(24'd3, 24'd9, 1'b1, 1'b1);
        set_weights(16'hffff, 16'hffff, 16'hffff);
        random_series(6);
        set_weights(16'hffff, 16'd0, 16'h0001);

        // phase one: sender 16%, receiver 83%
        idle_tx = 16; idle_rx = 83;
        while (fed < 560) random_series($urandom_range(2, 12));
        drain(); // sender holds off until all scores are back
        set_weights(16'd128, 16'd512, 16'd256);
        idle_tx = 83; idle_rx = 16;
        while (fed < 1100) random_series($urandom_range(2, 12));
        set_weights(16'd256, 16'd256, 16'd256);
        idle_tx = 0; idle_rx = 0;
        while (fed < 1640) random_series($urandom_range(1, 12));

        drain();
        if (errors == 0 && score_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ===== weighted_kling_gupta_efficiency.f =====
src/wkge_pkg.sv
src/wkge_if.sv
src/wkge_arith.sv
src/wkge_ctrl.sv
src/wkge_dp.sv
src/weighted_kling_gupta_efficiency.sv
test/wkge_tb_if.sv
test/tb_top.sv
